>>> hw/rtl/utoq_pkg.sv
// Package for the serial transmit overwrite queue.
// Function codes, ASCII constants and the hex digit lookup.
// No dependencies.
`default_nettype none
package utoq_pkg;

	typedef logic [1:0] func_t;

	localparam func_t FN_PUT_BYTE = 2'd0;
	localparam func_t FN_PUT_HEX  = 2'd1;
	localparam func_t FN_PUT_DEC  = 2'd2;
	localparam func_t FN_TX_DONE  = 2'd3;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			hex_digit = CH_ZERO + {4'd0, nib};
		end else begin
			hex_digit = CH_UPPER_A + {4'd0, nib - 4'd10};
		end
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/uart_tx_overwrite_queue_top.sv
// Serial transmit ring queue, oldest byte overwritten when full, with line busy flag.
// Depends on utoq_pkg and utoq_fmt.
//
// channel  direction  handshake            payload
// in       receive    in_valid / in_stall  func[1:0], data_byte[7:0]
// out      send       out_valid/out_stall  line_byte[7:0]
//
// The single-port queue memory writes one byte per cycle and has a registered
// read. A transmit complete on an empty queue reads nothing from the queue.
// A result waits in the output register; the next transaction is taken
// meanwhile and stalls only when it needs that register.
// Reset clears pointers, count and busy flag; queue memory is not cleared.
`default_nettype none
module uart_tx_overwrite_queue_top #(
	parameter int QUEUE_DEPTH = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire utoq_pkg::func_t func,
	input  wire logic [7:0]      data_byte,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           line_byte
);
	import utoq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PUT   = 2'd1;
	localparam logic [1:0] ST_TXOUT = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       idx_q;
	func_t            func_q;
	logic [7:0]       data_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             busy_q;
	logic             out_valid_q;
	logic [7:0]       line_byte_q;
	logic [7:0]       mem_q [QUEUE_DEPTH];
	logic [7:0]       rd_data_q;

	logic             in_acc;
	logic             out_free;
	logic             out_load;
	logic             mem_we;
	logic             mem_re;
	logic             put_step;
	logic             put_last;
	logic [7:0]       put_byte;
	logic [PTR_W-1:0] wr_ptr_nx;
	logic [PTR_W-1:0] rd_ptr_nx;
	logic             full;

	utoq_fmt u_fmt (
		.func      (func_q),
		.data_byte (data_q),
		.idx       (idx_q),
		.line_byte (put_byte)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign line_byte = line_byte_q;

	assign full      = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign wr_ptr_nx = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_nx = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	// idle line means empty queue: first byte goes straight out
	assign put_step = (state_q == ST_PUT) & (busy_q | out_free);
	assign mem_we   = (state_q == ST_PUT) & busy_q;
	assign put_last = (func_q == FN_PUT_BYTE) | (idx_q == 2'd3);
	assign mem_re   = in_acc & (func == FN_TX_DONE) & (fill_q != '0);
	assign out_load = (put_step & ~busy_q) | ((state_q == ST_TXOUT) & out_free);

	// read and write never share a cycle: one port is enough
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_ptr_q] <= put_byte;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			data_q <= data_byte;
		end
		if (state_q == ST_PUT && !busy_q && out_free) begin
			line_byte_q <= put_byte;
		end else if (state_q == ST_TXOUT && out_free) begin
			line_byte_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load | (out_valid_q & out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						if (func != FN_TX_DONE) begin
							state_q <= ST_PUT;
						end else if (fill_q != '0) begin
							state_q <= ST_TXOUT;
						end else begin
							busy_q <= 1'b0;
						end
					end
				end
				ST_PUT: begin
					if (put_step) begin
						if (!busy_q) begin
							busy_q <= 1'b1;
						end else begin
							wr_ptr_q <= wr_ptr_nx;
							if (full) begin
								rd_ptr_q <= rd_ptr_nx;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
						idx_q <= idx_q + 1'b1;
						if (put_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TXOUT: begin
					if (out_free) begin
						rd_ptr_q <= rd_ptr_nx;
						fill_q   <= fill_q - 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> fill_q == '0)
		else $error("line idle with bytes queued");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && func == FN_TX_DONE && fill_q == '0) |=> !busy_q && state_q == ST_IDLE)
		else $error("transmit complete on empty queue left line busy");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> !(state_q == ST_PUT && $past(state_q) == ST_PUT
			&& $past(!busy_q) && busy_q && $past(idx_q) != idx_q))
		else $error("result loaded over a held output");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/utoq_fmt.sv
// Byte formatter: gives byte idx of a plain, hex or decimal put.
// Depends on utoq_pkg.
`default_nettype none
module utoq_fmt (
	input  wire utoq_pkg::func_t func,
	input  wire logic [7:0]      data_byte,
	input  wire logic [1:0]      idx,
	output logic [7:0]           line_byte
);
	import utoq_pkg::*;

	logic [1:0]  hund;
	logic [6:0]  rem;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [3:0]  units;
	logic [7:0]  hex_b;
	logic [7:0]  dec_b;

	// /10 by reciprocal, exact for rem below 100
	always_comb begin
		if (data_byte >= 8'd200) begin
			hund = 2'd2;
			rem  = 7'(data_byte - 8'd200);
		end else if (data_byte >= 8'd100) begin
			hund = 2'd1;
			rem  = 7'(data_byte - 8'd100);
		end else begin
			hund = 2'd0;
			rem  = data_byte[6:0];
		end
		prod  = 15'(rem) * 15'd205;
		tens  = prod[14:11];
		units = 4'(rem - 7'(tens) * 7'd10);
	end

	always_comb begin
		case (idx)
			2'd0:    hex_b = CH_LBRACK;
			2'd1:    hex_b = hex_digit(data_byte[7:4]);
			2'd2:    hex_b = hex_digit(data_byte[3:0]);
			default: hex_b = CH_RBRACK;
		endcase
		case (idx)
			2'd0:    dec_b = CH_ZERO + {6'd0, hund};
			2'd1:    dec_b = CH_ZERO + {4'd0, tens};
			2'd2:    dec_b = CH_ZERO + {4'd0, units};
			default: dec_b = CH_SPACE;
		endcase
		case (func)
			FN_PUT_HEX: line_byte = hex_b;
			FN_PUT_DEC: line_byte = dec_b;
			default:    line_byte = data_byte;
		endcase
	end

endmodule
`default_nettype wire
